FILE: rtl/dob_pkg.sv
// dob_pkg: shared types and constants for the disturbance observer.
// Used by dob_mul and disturbance_observer_biquad; depends on nothing.
`default_nettype none

package dob_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int IO_W        = 32;
	// wide enough for any product shift up to 30
	localparam int SHIFT_W     = 5;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ENABLE           = 3'd0,
		CFG_NOMINAL_INERTIA  = 3'd1,
		CFG_NOMINAL_FRICTION = 3'd2,
		CFG_ESTIMATE_LIMIT   = 3'd3,
		CFG_FEED_GAIN        = 3'd4,
		CFG_FEEDBACK_ONE     = 3'd5,
		CFG_FEEDBACK_TWO     = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic signed [IO_W-1:0] torque_command;
		logic signed [IO_W-1:0] joint_velocity;
		logic signed [IO_W-1:0] joint_acceleration;
	} dob_in_t;

	typedef struct packed {
		logic signed [IO_W-1:0] disturbance_estimate;
		logic                   was_clamped;
	} dob_out_t;

	typedef struct packed {
		logic               start;
		logic [SHIFT_W-1:0] shift;
	} mul_req_t;

endpackage

`default_nettype wire

FILE: rtl/dob_mul.sv
// dob_mul: bit-serial signed multiplier with round half away from zero,
// right shift and saturation to DW bits. Depends on dob_pkg.
`default_nettype none

module dob_mul #(
	parameter int MW = 32,
	parameter int DW = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dob_pkg::mul_req_t      req,
	input  wire logic signed [MW-1:0]   a,
	input  wire logic signed [MW-1:0]   b,
	output logic                        done,
	output logic signed [DW-1:0]        product
);

	localparam int PW  = 2 * MW;
	localparam int CW  = $clog2(MW + 1);
	localparam logic [PW-1:0] LIM  = PW'(1) << (DW - 1);
	localparam logic [PW-1:0] DMAX = LIM - PW'(1);

	typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

	mstate_t                     state_q;
	logic [CW-1:0]               cnt_q;
	logic [PW-1:0]               mcand_q;
	logic [MW-1:0]               mplier_q;
	logic [PW-1:0]               acc_q;
	logic                        neg_q;
	logic [dob_pkg::SHIFT_W-1:0] shift_q;
	logic [MW-1:0]               ua, ub;
	logic [PW-1:0]               mag;
	logic [PW-1:0]               mag_sat;

	assign ua = a[MW-1] ? MW'(-a) : MW'(a);
	assign ub = b[MW-1] ? MW'(-b) : MW'(b);

	always_comb begin
		mag     = acc_q >> shift_q;
		mag_sat = (mag > LIM) ? LIM : mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						mcand_q  <= PW'(ua);
						mplier_q <= ub;
						// rounding half folded into the accumulator start value
						acc_q    <= PW'(1) << (req.shift - dob_pkg::SHIFT_W'(1));
						neg_q    <= a[MW-1] ^ b[MW-1];
						shift_q  <= req.shift;
						cnt_q    <= CW'(MW);
						state_q  <= M_RUN;
					end
				end
				M_RUN: begin
					if (mplier_q[0])
						acc_q <= acc_q + mcand_q;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - CW'(1);
					if (cnt_q == CW'(1))
						state_q <= M_FIN;
				end
				M_FIN: begin
					if (neg_q)
						product <= -$signed(mag_sat[DW-1:0]);
					else if (mag_sat > DMAX)
						product <= $signed(DMAX[DW-1:0]);
					else
						product <= $signed(mag_sat[DW-1:0]);
					done    <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == M_FIN)
		else $error("multiplier done without finishing pass");

	a_start_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == M_IDLE && req.start) |=> state_q == M_RUN)
		else $error("multiplier did not start");

	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == M_RUN |-> cnt_q != '0)
		else $error("multiplier bit count underflow");

endmodule

`default_nettype wire

FILE: rtl/disturbance_observer_biquad.sv
// Disturbance observer: model subtraction, biquad low-pass and clamp.
// Top level; instantiates dob_mul, depends on dob_pkg.
//
// One request takes 7 products on a single bit-serial multiplier of
// MW = max(DATA_WIDTH,32) bits, plus sequencing steps for accept, model
// subtraction, clamp and output. A disabled block answers with a zero
// estimate without using the multiplier and leaves the filter history
// alone. The output register lets a new request be taken while a result
// still waits. Configuration is written through cfg_wr_en / cfg_index /
// cfg_data; the user must write it only while idle, which the block itself
// does not enforce. Unknown indices are ignored.
`default_nettype none

module disturbance_observer_biquad #(
	parameter int DATA_WIDTH     = 32,
	parameter int DATA_FRAC_BITS = 16,
	parameter int COEF_FRAC_BITS = 30
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [dob_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [dob_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire dob_pkg::dob_in_t                   in_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output dob_pkg::dob_out_t                       out_data
);

	localparam int DW = DATA_WIDTH;
	localparam int MW = (DW > 32) ? DW : 32;
	localparam int W  = MW + 1;
	localparam logic signed [W-1:0] DMAX_W = W'((64'sd1 <<< (DW - 1)) - 64'sd1);
	localparam logic signed [W-1:0] DMIN_W = -DMAX_W - W'(1);

	typedef enum logic [2:0] {S_IDLE, S_START, S_WAIT, S_RAW, S_CLAMP, S_OUT} state_t;
	typedef enum logic [2:0] {
		ST_INERTIA, ST_FRICTION, ST_B0X, ST_B1X1, ST_B2X2, ST_A1Y1, ST_A2Y2
	} step_t;

	state_t state_q;
	step_t  step_q;

	logic               enable_q;
	logic signed [31:0] inertia_q, friction_q, b0_q, a1_q, a2_q;
	logic [30:0]        limit_q;

	logic signed [DW-1:0] tc_q, vel_q, accel_q, raw_q, y_q;
	logic signed [DW-1:0] x1_q, x2_q, y1_q, y2_q;

	logic                 out_valid_q;
	dob_pkg::dob_out_t    out_data_q;
	dob_pkg::dob_out_t    result_q;

	dob_pkg::mul_req_t    mreq;
	logic signed [MW-1:0] op_a, op_b;
	logic                 mdone;
	logic signed [DW-1:0] mprod;

	logic signed [W-1:0]  y_w, lim_w, nlim_w;
	logic signed [DW-1:0] acc_next;

	function automatic logic signed [DW-1:0] sat_in(input logic signed [31:0] v);
		logic signed [W-1:0] e;
		e = W'(v);
		if (e > DMAX_W)
			return DMAX_W[DW-1:0];
		else if (e < DMIN_W)
			return DMIN_W[DW-1:0];
		else
			return e[DW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] sat_sum(input logic signed [DW-1:0] x,
			input logic signed [DW-1:0] z, input logic sub);
		logic signed [DW:0] s;
		s = sub ? ((DW+1)'(x) - (DW+1)'(z)) : ((DW+1)'(x) + (DW+1)'(z));
		if (s[DW] != s[DW-1])
			return s[DW] ? DMIN_W[DW-1:0] : DMAX_W[DW-1:0];
		else
			return s[DW-1:0];
	endfunction

	// operand and shift selection for the current product
	always_comb begin
		mreq.start = (state_q == S_START);
		mreq.shift = dob_pkg::SHIFT_W'(COEF_FRAC_BITS);
		op_a       = MW'(b0_q);
		op_b       = MW'(raw_q);
		case (step_q)
			ST_INERTIA: begin
				op_a = MW'(inertia_q); op_b = MW'(accel_q);
				mreq.shift = dob_pkg::SHIFT_W'(DATA_FRAC_BITS);
			end
			ST_FRICTION: begin
				op_a = MW'(friction_q); op_b = MW'(vel_q);
				mreq.shift = dob_pkg::SHIFT_W'(DATA_FRAC_BITS);
			end
			ST_B0X: begin
				op_a = MW'(b0_q); op_b = MW'(raw_q);
			end
			ST_B1X1: begin
				// doubled b0: one fraction bit fewer
				op_a = MW'(b0_q); op_b = MW'(x1_q);
				mreq.shift = dob_pkg::SHIFT_W'(COEF_FRAC_BITS - 1);
			end
			ST_B2X2: begin
				op_a = MW'(b0_q); op_b = MW'(x2_q);
			end
			ST_A1Y1: begin
				op_a = MW'(a1_q); op_b = MW'(y1_q);
			end
			ST_A2Y2: begin
				op_a = MW'(a2_q); op_b = MW'(y2_q);
			end
			default: begin
				op_a = MW'(b0_q); op_b = MW'(raw_q);
			end
		endcase
	end

	always_comb begin
		case (step_q)
			ST_INERTIA, ST_B0X: acc_next = mprod;
			ST_A1Y1, ST_A2Y2:   acc_next = sat_sum(y_q, mprod, 1'b1);
			default:            acc_next = sat_sum(y_q, mprod, 1'b0);
		endcase
	end

	always_comb begin
		y_w    = W'(y_q);
		lim_w  = $signed(W'(limit_q));
		nlim_w = -lim_w;
	end

	dob_mul #(.MW(MW), .DW(DW)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.a       (op_a),
		.b       (op_b),
		.done    (mdone),
		.product (mprod)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			inertia_q  <= '0;
			friction_q <= '0;
			limit_q    <= '0;
			b0_q       <= '0;
			a1_q       <= '0;
			a2_q       <= '0;
		end else if (cfg_wr_en) begin
			case (dob_pkg::cfg_index_t'(cfg_index))
				dob_pkg::CFG_ENABLE:           enable_q   <= cfg_data[0];
				dob_pkg::CFG_NOMINAL_INERTIA:  inertia_q  <= $signed(cfg_data);
				dob_pkg::CFG_NOMINAL_FRICTION: friction_q <= $signed(cfg_data);
				dob_pkg::CFG_ESTIMATE_LIMIT:   limit_q    <= cfg_data[30:0];
				dob_pkg::CFG_FEED_GAIN:        b0_q       <= $signed(cfg_data);
				dob_pkg::CFG_FEEDBACK_ONE:     a1_q       <= $signed(cfg_data);
				dob_pkg::CFG_FEEDBACK_TWO:     a2_q       <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// sequencer, filter history and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_INERTIA;
			out_valid_q <= 1'b0;
			x1_q        <= '0;
			x2_q        <= '0;
			y1_q        <= '0;
			y2_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						tc_q    <= sat_in(in_data.torque_command);
						vel_q   <= sat_in(in_data.joint_velocity);
						accel_q <= sat_in(in_data.joint_acceleration);
						step_q  <= ST_INERTIA;
						if (enable_q) begin
							state_q <= S_START;
						end else begin
							result_q <= '0;
							state_q  <= S_OUT;
						end
					end
				end
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (mdone) begin
						y_q <= acc_next;
						case (step_q)
							ST_FRICTION: state_q <= S_RAW;
							ST_A2Y2:     state_q <= S_CLAMP;
							default:     state_q <= S_START;
						endcase
						if (step_q != ST_FRICTION && step_q != ST_A2Y2)
							step_q <= step_t'(step_q + 3'd1);
					end
				end
				S_RAW: begin
					raw_q   <= sat_sum(tc_q, y_q, 1'b1);
					step_q  <= ST_B0X;
					state_q <= S_START;
				end
				S_CLAMP: begin
					x2_q <= x1_q;
					x1_q <= raw_q;
					y2_q <= y1_q;
					y1_q <= y_q;
					if (y_w > lim_w) begin
						result_q.disturbance_estimate <= lim_w[31:0];
						result_q.was_clamped          <= 1'b1;
					end else if (y_w < nlim_w) begin
						result_q.disturbance_estimate <= nlim_w[31:0];
						result_q.was_clamped          <= 1'b1;
					end else begin
						result_q.disturbance_estimate <= y_w[31:0];
						result_q.was_clamped          <= 1'b0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_data_q  <= result_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted but block not busy");

	a_done_while_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mdone |-> state_q == S_WAIT)
		else $error("product returned outside wait state");

	a_clamp_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.was_clamped) |->
		(out_data.disturbance_estimate == {1'b0, limit_q} ||
		 out_data.disturbance_estimate == -{1'b0, limit_q}))
		else $error("clamped estimate differs from limit");

endmodule

`default_nettype wire

FILE: sim/disturbance_observer_biquad_tb.sv
// Testbench for disturbance_observer_biquad: predicts each estimate in fixed point
// and checks it against the block's output under random idling and stalls.
// Depends on dob_pkg and the RTL top level only.
`timescale 1ns / 1ps

module disturbance_observer_biquad_tb;

	localparam longint DMAX = 64'sd2147483647;
	localparam longint DMIN = -64'sd2147483648;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [dob_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [dob_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	dob_pkg::dob_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	dob_pkg::dob_out_t out_data;

	disturbance_observer_biquad u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state and register copy
	logic   obs_enable;
	longint inertia, friction, limit, gain_b0, gain_a1, gain_a2;
	longint raw_d1, raw_d2, filt_d1, filt_d2;

	dob_pkg::dob_in_t  pending_samples[$];
	dob_pkg::dob_out_t expected_estimates[$];
	int mismatches = 0;
	int unexpected = 0;
	int idle_cycles = 0;
	bit timed_out = 1'b0;
	bit hold_sender = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;

	function automatic longint sat_data(longint x);
		if (x > DMAX) return DMAX;
		if (x < DMIN) return DMIN;
		return x;
	endfunction

	// exact product, shifted right with rounding half away from zero, saturated
	function automatic longint mul_round(longint a, longint b, int s);
		logic signed [127:0] p;
		logic [127:0] mag;
		bit neg;
		p = 128'(a) * 128'(b);
		neg = p < 0;
		mag = neg ? 128'(-p) : 128'(p);
		mag = (mag + (128'd1 << (s - 1))) >> s;
		if (neg) begin
			if (mag > 128'd2147483648) return DMIN;
			return -longint'(mag);
		end
		if (mag > 128'd2147483647) return DMAX;
		return longint'(mag);
	endfunction

	function automatic dob_pkg::dob_out_t predict_estimate(dob_pkg::dob_in_t s);
		dob_pkg::dob_out_t r;
		longint model, raw, y;
		r = '0;
		if (!obs_enable) return r;
		model = sat_data(mul_round(inertia, longint'(s.joint_acceleration), 16) +
			mul_round(friction, longint'(s.joint_velocity), 16));
		raw = sat_data(longint'(s.torque_command) - model);
		y = mul_round(gain_b0, raw, 30);
		y = sat_data(y + mul_round(gain_b0, raw_d1, 29));
		y = sat_data(y + mul_round(gain_b0, raw_d2, 30));
		y = sat_data(y - mul_round(gain_a1, filt_d1, 30));
		y = sat_data(y - mul_round(gain_a2, filt_d2, 30));
		raw_d2 = raw_d1;
		raw_d1 = raw;
		filt_d2 = filt_d1;
		filt_d1 = y;
		if (y > limit) begin
			y = limit;
			r.was_clamped = 1'b1;
		end else if (y < -limit) begin
			y = -limit;
			r.was_clamped = 1'b1;
		end
		r.disturbance_estimate = y[31:0];
		return r;
	endfunction

	// driver: bursts and gaps; a request is held until taken
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_estimates.push_back(predict_estimate(in_data));
			void'(pending_samples.pop_front());
		end
		if (in_valid && in_stall) begin
			// keep the stalled request unchanged
		end else if (hold_sender || pending_samples.size() == 0 ||
				(in_valid && !in_stall && pending_samples.size() == 0)) begin
			in_valid <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else begin
			in_valid <= 1'b1;
			in_data <= pending_samples[0];
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 12);
				gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end
	end

	// monitor and receiver stall pattern
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_estimates.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("unexpected result %h", out_data);
			end else begin
				if (out_data !== expected_estimates[0]) begin
					mismatches++;
					if (mismatches + unexpected <= 10)
						$display("mismatch: expected est=%h clamp=%b, got est=%h clamp=%b",
							expected_estimates[0].disturbance_estimate,
							expected_estimates[0].was_clamped,
							out_data.disturbance_estimate, out_data.was_clamped);
				end
				void'(expected_estimates.pop_front());
			end
		end
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(dob_pkg::cfg_index_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			dob_pkg::CFG_ENABLE:           obs_enable = value[0];
			dob_pkg::CFG_NOMINAL_INERTIA:  inertia = longint'(signed'(value));
			dob_pkg::CFG_NOMINAL_FRICTION: friction = longint'(signed'(value));
			dob_pkg::CFG_ESTIMATE_LIMIT:   limit = longint'({1'b0, value[30:0]});
			dob_pkg::CFG_FEED_GAIN:        gain_b0 = longint'(signed'(value));
			dob_pkg::CFG_FEEDBACK_ONE:     gain_a1 = longint'(signed'(value));
			dob_pkg::CFG_FEEDBACK_TWO:     gain_a2 = longint'(signed'(value));
			default: ;
		endcase
	endtask

	task automatic drain;
		while (pending_samples.size() != 0 || in_valid || expected_estimates.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return $urandom;
		endcase
	endfunction

	task automatic add_sample(logic [31:0] t, logic [31:0] v, logic [31:0] a);
		dob_pkg::dob_in_t s;
		s.torque_command = t;
		s.joint_velocity = v;
		s.joint_acceleration = a;
		pending_samples.push_back(s);
	endtask

	task automatic random_phase(int count, bit small_vals);
		repeat (count) begin
			if (small_vals)
				add_sample(32'(signed'($urandom_range(0, 1 << 22)) - (1 << 21)),
					32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17)),
					32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17)));
			else
				add_sample(rand_word(), rand_word(), rand_word());
		end
	endtask

	initial begin
		obs_enable = 1'b0;
		inertia = 0; friction = 0; limit = 0;
		gain_b0 = 0; gain_a1 = 0; gain_a2 = 0;
		raw_d1 = 0; raw_d2 = 0; filt_d1 = 0; filt_d2 = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset: zero output, history untouched
		add_sample(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
		add_sample(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
		drain();

		// directed: extremes, saturation, clamp both ways
		write_reg(dob_pkg::CFG_ENABLE, 32'd1);
		write_reg(dob_pkg::CFG_NOMINAL_INERTIA, 32'h7fff_ffff);
		write_reg(dob_pkg::CFG_NOMINAL_FRICTION, 32'h8000_0000);
		write_reg(dob_pkg::CFG_ESTIMATE_LIMIT, 32'h0001_0000);
		write_reg(dob_pkg::CFG_FEED_GAIN, 32'h4000_0000);
		write_reg(dob_pkg::CFG_FEEDBACK_ONE, 32'h8000_0000);
		write_reg(dob_pkg::CFG_FEEDBACK_TWO, 32'h7fff_ffff);
		add_sample(32'h0, 32'h0, 32'h0);
		add_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		add_sample(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		add_sample(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
		add_sample(32'h0000_8000, 32'hffff_8000, 32'h0000_8000);
		add_sample(32'h0001_0000, 32'h0, 32'h0);
		add_sample(32'hffff_0000, 32'h0, 32'h0);
		add_sample(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
		drain();
		write_reg(dob_pkg::CFG_ESTIMATE_LIMIT, 32'hffff_ffff);
		write_reg(dob_pkg::CFG_FEEDBACK_ONE, 32'h0);
		write_reg(dob_pkg::CFG_FEEDBACK_TWO, 32'h0);
		write_reg(dob_pkg::CFG_NOMINAL_INERTIA, 32'h0001_0000);
		write_reg(dob_pkg::CFG_NOMINAL_FRICTION, 32'h0000_8000);
		add_sample(32'h7fff_ffff, 32'h0, 32'h0);
		add_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		add_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_sample(32'h0000_0001, 32'h0000_0001, 32'hffff_ffff);
		drain();
		// disable mid-history, then resume
		write_reg(dob_pkg::CFG_ENABLE, 32'd0);
		add_sample(32'h1234_0000, 32'h0, 32'h0);
		drain();
		write_reg(dob_pkg::CFG_ENABLE, 32'd1);

		// random phases: alternately a stable low-pass and random coefficients
		for (int ph = 0; ph < 8; ph++) begin
			if (ph % 2 == 0) begin
				write_reg(dob_pkg::CFG_FEED_GAIN,
					32'h0040_0000 + $urandom_range(0, 32'h0040_0000));
				write_reg(dob_pkg::CFG_FEEDBACK_ONE,
					32'hc000_0000 + $urandom_range(0, 32'h0400_0000));
				write_reg(dob_pkg::CFG_FEEDBACK_TWO,
					32'h0800_0000 + $urandom_range(0, 32'h0800_0000));
				write_reg(dob_pkg::CFG_NOMINAL_INERTIA,
					32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19)));
				write_reg(dob_pkg::CFG_NOMINAL_FRICTION,
					32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17)));
				write_reg(dob_pkg::CFG_ESTIMATE_LIMIT, $urandom_range(0, 1 << 24));
			end else begin
				write_reg(dob_pkg::CFG_FEED_GAIN, rand_word());
				write_reg(dob_pkg::CFG_FEEDBACK_ONE, rand_word());
				write_reg(dob_pkg::CFG_FEEDBACK_TWO, rand_word());
				write_reg(dob_pkg::CFG_NOMINAL_INERTIA, rand_word());
				write_reg(dob_pkg::CFG_NOMINAL_FRICTION, rand_word());
				write_reg(dob_pkg::CFG_ESTIMATE_LIMIT,
					($urandom_range(0, 3) == 0) ? 32'h0 : $urandom);
			end
			write_reg(dob_pkg::CFG_ENABLE, (ph == 5) ? 32'd0 : 32'd1);
			random_phase(50, ph % 2 == 0);
			if (ph == 3) begin
				// sender holds off until every result is in
				while (pending_samples.size() != 0 || in_valid) @(posedge clk);
				hold_sender = 1'b1;
				while (expected_estimates.size() != 0) @(posedge clk);
				hold_sender = 1'b0;
			end
			random_phase(50, ph % 2 == 0);
			drain();
		end

		if (mismatches == 0 && unexpected == 0 && expected_estimates.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
